### rtl/core/gcd_pkg.sv
// Package for the great-circle distance pipeline: field widths, fixed-point
// formats, CORDIC arctangent table and reset constants.
// No dependencies; every other file imports it.
package gcd_pkg;

    // Input angles carry this many fraction bits (degrees times 2^F)
    localparam int ANGLE_FRAC_BITS      = 16;
    localparam int CORDIC_STEPS_DEFAULT = 24;
    localparam int CORDIC_STEPS_MAX     = 32;

    // Field widths
    localparam int RA_W     = 25;
    localparam int DEC_W    = 24;
    localparam int RADIUS_W = 26;
    localparam int DIST_W   = 28;

    // Configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // Internal formats
    localparam int ANGLE_W = 32;   // binary angle, 2^32 per full turn
    localparam int TRIG_W  = 33;   // signed Q30
    localparam int ROOT_W  = 31;   // unsigned Q30, 0 to 1
    localparam int LANES   = 4;

    // Angle lanes through conversion and sine/cosine
    localparam int LANE_DDEC = 0;  // half declination difference, sine
    localparam int LANE_DRA  = 1;  // half ascension difference, sine
    localparam int LANE_DEC1 = 2;  // first declination, cosine
    localparam int LANE_DEC2 = 3;  // second declination, cosine

    typedef logic [ANGLE_W-1:0]        angle_t;
    typedef logic signed [TRIG_W-1:0]  trig_t;
    typedef logic [ROOT_W-1:0]         root_t;

    localparam root_t Q30_ONE = 31'h4000_0000;

    localparam logic [RADIUS_W-1:0] RADIUS_RESET    = 26'd6371000;
    localparam trig_t               CORDIC_GAIN_Q30 = 33'sh0_26DD_3B6A;
    localparam logic [29:0]         PI_Q28          = 30'd843314857;

    // Division by 45 through a reciprocal: q = (v * RECIP45) >> 31, one correction
    localparam int              CONV_DIV    = 45;
    localparam int              RECIP_SHIFT = 31;
    localparam logic [25:0]     RECIP45     = 26'd47721858;

    // atan(2^-i) in binary angle units
    localparam logic signed [31:0] ATAN_UNITS [CORDIC_STEPS_MAX] = '{
        32'sh2000_0000, 32'sh12E4_051E, 32'sh09FB_385B, 32'sh0511_11D4,
        32'sh028B_0D43, 32'sh0145_D7E1, 32'sh00A2_F61E, 32'sh0051_7C55,
        32'sh0028_BE53, 32'sh0014_5F2F, 32'sh000A_2F98, 32'sh0005_17CC,
        32'sh0002_8BE6, 32'sh0001_45F3, 32'sh0000_A2FA, 32'sh0000_517D,
        32'sh0000_28BE, 32'sh0000_145F, 32'sh0000_0A30, 32'sh0000_0518,
        32'sh0000_028C, 32'sh0000_0146, 32'sh0000_00A3, 32'sh0000_0051,
        32'sh0000_0029, 32'sh0000_0014, 32'sh0000_000A, 32'sh0000_0005,
        32'sh0000_0003, 32'sh0000_0001, 32'sh0000_0001, 32'sh0000_0000
    };

endpackage

### rtl/core/gcd_in_if.sv
// Input channel: one point pair per transfer, valid/ready handshake.
// Depends on gcd_pkg for field widths.
interface gcd_in_if import gcd_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [RA_W-1:0]         first_ascension;
    logic signed [DEC_W-1:0] first_declination;
    logic [RA_W-1:0]         second_ascension;
    logic signed [DEC_W-1:0] second_declination;

    modport source (
        output valid, first_ascension, first_declination,
               second_ascension, second_declination,
        input  ready
    );
    modport sink (
        input  valid, first_ascension, first_declination,
               second_ascension, second_declination,
        output ready
    );
endinterface

### rtl/core/gcd_out_if.sv
// Output channel: one distance per transfer, valid/ready handshake.
// Depends on gcd_pkg for the field width.
interface gcd_out_if import gcd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [DIST_W-1:0] distance;

    modport source (
        output valid, distance,
        input  ready
    );
    modport sink (
        input  valid, distance,
        output ready
    );
endinterface

### rtl/core/gcd_angle_conv.sv
// Three-stage conversion of degree angles to binary angles (2^32 per turn),
// rounded to nearest, ties away from zero. Depends on gcd_pkg.
module gcd_angle_conv
    import gcd_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    in_valid,
    input  logic [RA_W-1:0]         first_ascension,
    input  logic signed [DEC_W-1:0] first_declination,
    input  logic [RA_W-1:0]         second_ascension,
    input  logic signed [DEC_W-1:0] second_declination,
    output logic                    out_valid,
    output angle_t                  angle [LANES]
);
    localparam int MAG_W      = RA_W + 1;
    localparam int QUO_W      = 20;
    localparam int REM_W      = 6;
    localparam int PROD_W     = MAG_W + 26;
    // 2^(32-F)/720 = 2^(28-F)/45 and 2^(32-F)/360 = 2^(29-F)/45
    localparam int HALF_SHIFT = 28 - ANGLE_FRAC_BITS;
    localparam int FULL_SHIFT = 29 - ANGLE_FRAC_BITS;

    // Rounded contribution of the remainder, one table per divisor
    logic [ANGLE_W-1:0] tbl_half [CONV_DIV];
    logic [ANGLE_W-1:0] tbl_full [CONV_DIV];

    generate
        for (genvar g = 0; g < CONV_DIV; g++)
        begin : g_tbl
            assign tbl_half[g] = ANGLE_W'((g * (2 ** (32 - ANGLE_FRAC_BITS)) + 360) / 720);
            assign tbl_full[g] = ANGLE_W'((g * (2 ** (32 - ANGLE_FRAC_BITS)) + 180) / 360);
        end
    endgenerate

    logic [MAG_W-1:0] mag_a_reg  [LANES], mag_a_next  [LANES];
    logic [QUO_W-1:0] qest_a_reg [LANES], qest_a_next [LANES];
    logic             neg_a_reg  [LANES], neg_a_next  [LANES];
    logic [QUO_W-1:0] quo_b_reg  [LANES], quo_b_next  [LANES];
    logic [REM_W-1:0] rem_b_reg  [LANES], rem_b_next  [LANES];
    logic             neg_b_reg  [LANES];
    angle_t           angle_reg  [LANES], angle_next  [LANES];
    logic             vld_a_reg, vld_b_reg, vld_c_reg;

    // Stage A: signed operand, magnitude and estimated quotient by 45
    always_comb
    begin
        logic signed [MAG_W-1:0] val  [LANES];
        logic [PROD_W-1:0]       prod [LANES];
        val[LANE_DDEC] = {{(MAG_W-DEC_W){second_declination[DEC_W-1]}}, second_declination}
                       - {{(MAG_W-DEC_W){first_declination[DEC_W-1]}}, first_declination};
        val[LANE_DRA]  = {1'b0, second_ascension} - {1'b0, first_ascension};
        val[LANE_DEC1] = {{(MAG_W-DEC_W){first_declination[DEC_W-1]}}, first_declination};
        val[LANE_DEC2] = {{(MAG_W-DEC_W){second_declination[DEC_W-1]}}, second_declination};
        for (int l = 0; l < LANES; l++)
        begin
            neg_a_next[l]  = val[l][MAG_W-1];
            mag_a_next[l]  = val[l][MAG_W-1] ? MAG_W'(-val[l]) : MAG_W'(val[l]);
            prod[l]        = PROD_W'(mag_a_next[l]) * PROD_W'(RECIP45);
            qest_a_next[l] = prod[l][RECIP_SHIFT +: QUO_W];
        end
    end

    // Stage B: remainder and one correction step
    always_comb
    begin
        logic [MAG_W-1:0] diff [LANES];
        for (int l = 0; l < LANES; l++)
        begin
            diff[l] = mag_a_reg[l] - MAG_W'(qest_a_reg[l]) * MAG_W'(CONV_DIV);
            if (diff[l] >= MAG_W'(CONV_DIV))
            begin
                quo_b_next[l] = qest_a_reg[l] + QUO_W'(1);
                rem_b_next[l] = REM_W'(diff[l] - MAG_W'(CONV_DIV));
            end
            else
            begin
                quo_b_next[l] = qest_a_reg[l];
                rem_b_next[l] = REM_W'(diff[l]);
            end
        end
    end

    // Stage C: scale quotient, add rounded remainder term, restore sign
    always_comb
    begin
        angle_t scaled [LANES];
        for (int l = 0; l < LANES; l++)
        begin
            if (l == LANE_DDEC || l == LANE_DRA)
                scaled[l] = (ANGLE_W'(quo_b_reg[l]) << HALF_SHIFT) + tbl_half[rem_b_reg[l]];
            else
                scaled[l] = (ANGLE_W'(quo_b_reg[l]) << FULL_SHIFT) + tbl_full[rem_b_reg[l]];
            angle_next[l] = neg_b_reg[l] ? -scaled[l] : scaled[l];
        end
    end

    // Hold payload while stalled
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_a_reg  <= mag_a_next;
            qest_a_reg <= qest_a_next;
            neg_a_reg  <= neg_a_next;
            quo_b_reg  <= quo_b_next;
            rem_b_reg  <= rem_b_next;
            neg_b_reg  <= neg_a_reg;
            angle_reg  <= angle_next;
        end
    end

    // Advance valid bits with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_a_reg <= 1'b0;
            vld_b_reg <= 1'b0;
            vld_c_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_a_reg <= in_valid;
            vld_b_reg <= vld_a_reg;
            vld_c_reg <= vld_b_reg;
        end
    end

    assign out_valid = vld_c_reg;
    assign angle     = angle_reg;

endmodule

### rtl/core/gcd_sincos.sv
// Rotation-mode CORDIC, one iteration per stage, over four angle lanes.
// Lanes 0 and 1 give sines, lanes 2 and 3 cosines, Q30. Depends on gcd_pkg.
module gcd_sincos
    import gcd_pkg::*;
#(
    parameter int STEPS = CORDIC_STEPS_DEFAULT
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   en,
    input  logic   in_valid,
    input  angle_t angle [LANES],
    output logic   out_valid,
    output trig_t  value [LANES]
);
    trig_t              x_reg    [STEPS+1][LANES], x_next    [STEPS+1][LANES];
    trig_t              y_reg    [STEPS+1][LANES], y_next    [STEPS+1][LANES];
    logic signed [31:0] z_reg    [STEPS+1][LANES], z_next    [STEPS+1][LANES];
    logic [1:0]         quad_reg [STEPS+1][LANES], quad_next [STEPS+1][LANES];
    trig_t              value_reg [LANES], value_next [LANES];
    logic [STEPS:0]     vld_reg;
    logic               out_vld_reg;

    // Fold to the nearest quarter turn, then iterate
    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            quad_next[0][l] = 2'((angle[l] + 32'h2000_0000) >> 30);
            z_next[0][l]    = signed'(angle[l] - {quad_next[0][l], 30'b0});
            x_next[0][l]    = CORDIC_GAIN_Q30;
            y_next[0][l]    = '0;
        end
        for (int s = 0; s < STEPS; s++)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                quad_next[s+1][l] = quad_reg[s][l];
                if (!z_reg[s][l][31])
                begin
                    x_next[s+1][l] = x_reg[s][l] - (y_reg[s][l] >>> s);
                    y_next[s+1][l] = y_reg[s][l] + (x_reg[s][l] >>> s);
                    z_next[s+1][l] = z_reg[s][l] - ATAN_UNITS[s];
                end
                else
                begin
                    x_next[s+1][l] = x_reg[s][l] + (y_reg[s][l] >>> s);
                    y_next[s+1][l] = y_reg[s][l] - (x_reg[s][l] >>> s);
                    z_next[s+1][l] = z_reg[s][l] + ATAN_UNITS[s];
                end
            end
        end
    end

    // Undo the quadrant fold and pick sine or cosine per lane
    always_comb
    begin
        trig_t sin_v [LANES];
        trig_t cos_v [LANES];
        for (int l = 0; l < LANES; l++)
        begin
            case (quad_reg[STEPS][l])
                2'd0:
                begin
                    sin_v[l] = y_reg[STEPS][l];
                    cos_v[l] = x_reg[STEPS][l];
                end
                2'd1:
                begin
                    sin_v[l] = x_reg[STEPS][l];
                    cos_v[l] = -y_reg[STEPS][l];
                end
                2'd2:
                begin
                    sin_v[l] = -y_reg[STEPS][l];
                    cos_v[l] = -x_reg[STEPS][l];
                end
                default:
                begin
                    sin_v[l] = -x_reg[STEPS][l];
                    cos_v[l] = y_reg[STEPS][l];
                end
            endcase
            value_next[l] = (l == LANE_DDEC || l == LANE_DRA) ? sin_v[l] : cos_v[l];
        end
    end

    // Hold payload while stalled
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg     <= x_next;
            y_reg     <= y_next;
            z_reg     <= z_next;
            quad_reg  <= quad_next;
            value_reg <= value_next;
        end
    end

    // Advance valid bits with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg     <= {vld_reg[STEPS-1:0], in_valid};
            out_vld_reg <= vld_reg[STEPS];
        end
    end

    assign out_valid = out_vld_reg;
    assign value     = value_reg;

endmodule

### rtl/core/gcd_sqrt.sv
// Pipelined digit-recurrence square roots of a*2^30 and (1-a)*2^30,
// one result bit per stage, rounded to nearest. Depends on gcd_pkg.
module gcd_sqrt
    import gcd_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  en,
    input  logic  in_valid,
    input  root_t hav,
    output logic  out_valid,
    output root_t root_a,
    output root_t root_b
);
    localparam int RAD_W  = 2 * (ROOT_W - 1) + 1;   // radicand up to 2^60
    localparam int ACC_W  = RAD_W + 1;
    localparam int NBITS  = ROOT_W;                  // result bits
    localparam int NROOTS = 2;

    logic [ACC_W-1:0] rem_reg [NBITS+1][NROOTS], rem_next [NBITS+1][NROOTS];
    logic [ACC_W-1:0] res_reg [NBITS+1][NROOTS], res_next [NBITS+1][NROOTS];
    root_t            root_reg [NROOTS], root_next [NROOTS];
    logic [NBITS:0]   vld_reg;
    logic             out_vld_reg;

    // Load radicands, then one restoring step per stage
    always_comb
    begin
        logic [ACC_W-1:0] bit_v;
        logic [ACC_W-1:0] trial;
        rem_next[0][0] = ACC_W'({hav, 30'b0});
        rem_next[0][1] = ACC_W'({Q30_ONE - hav, 30'b0});
        res_next[0][0] = '0;
        res_next[0][1] = '0;
        for (int i = 0; i < NBITS; i++)
        begin
            bit_v = ACC_W'(1) << (RAD_W - 1 - 2 * i);
            for (int r = 0; r < NROOTS; r++)
            begin
                trial = res_reg[i][r] + bit_v;
                if (rem_reg[i][r] >= trial)
                begin
                    rem_next[i+1][r] = rem_reg[i][r] - trial;
                    res_next[i+1][r] = (res_reg[i][r] >> 1) + bit_v;
                end
                else
                begin
                    rem_next[i+1][r] = rem_reg[i][r];
                    res_next[i+1][r] = res_reg[i][r] >> 1;
                end
            end
        end
        // Round up when the remainder passes the root
        for (int r = 0; r < NROOTS; r++)
        begin
            if (rem_reg[NBITS][r] > res_reg[NBITS][r])
                root_next[r] = ROOT_W'(res_reg[NBITS][r] + ACC_W'(1));
            else
                root_next[r] = ROOT_W'(res_reg[NBITS][r]);
        end
    end

    // Hold payload while stalled
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_next;
            res_reg  <= res_next;
            root_reg <= root_next;
        end
    end

    // Advance valid bits with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg     <= {vld_reg[NBITS-1:0], in_valid};
            out_vld_reg <= vld_reg[NBITS];
        end
    end

    assign out_valid = out_vld_reg;
    assign root_a    = root_reg[0];
    assign root_b    = root_reg[1];

endmodule

### rtl/core/gcd_atan.sv
// Vectoring-mode CORDIC for atan2(y, x), one iteration per stage; the
// angle is clamped to a quarter turn. Depends on gcd_pkg.
module gcd_atan
    import gcd_pkg::*;
#(
    parameter int STEPS = CORDIC_STEPS_DEFAULT
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  en,
    input  logic  in_valid,
    input  root_t y_in,
    input  root_t x_in,
    output logic  out_valid,
    output root_t half_angle
);
    localparam int VEC_W = ROOT_W + 4;
    localparam int ZW    = 33;

    logic signed [VEC_W-1:0] x_reg [STEPS+1], x_next [STEPS+1];
    logic signed [VEC_W-1:0] y_reg [STEPS+1], y_next [STEPS+1];
    logic signed [ZW-1:0]    z_reg [STEPS+1], z_next [STEPS+1];
    root_t                   ang_reg, ang_next;
    logic [STEPS:0]          vld_reg;
    logic                    out_vld_reg;

    // Drive y towards zero, accumulating the angle
    always_comb
    begin
        x_next[0] = VEC_W'(x_in);
        y_next[0] = VEC_W'(y_in);
        z_next[0] = '0;
        for (int s = 0; s < STEPS; s++)
        begin
            if (!y_reg[s][VEC_W-1])
            begin
                x_next[s+1] = x_reg[s] + (y_reg[s] >>> s);
                y_next[s+1] = y_reg[s] - (x_reg[s] >>> s);
                z_next[s+1] = z_reg[s] + ZW'(ATAN_UNITS[s]);
            end
            else
            begin
                x_next[s+1] = x_reg[s] - (y_reg[s] >>> s);
                y_next[s+1] = y_reg[s] + (x_reg[s] >>> s);
                z_next[s+1] = z_reg[s] - ZW'(ATAN_UNITS[s]);
            end
        end
        // Clamp to zero .. a quarter turn
        if (z_reg[STEPS][ZW-1])
            ang_next = '0;
        else if (z_reg[STEPS] > signed'(ZW'(Q30_ONE)))
            ang_next = Q30_ONE;
        else
            ang_next = ROOT_W'(z_reg[STEPS]);
    end

    // Hold payload while stalled
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg   <= x_next;
            y_reg   <= y_next;
            z_reg   <= z_next;
            ang_reg <= ang_next;
        end
    end

    // Advance valid bits with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg     <= {vld_reg[STEPS-1:0], in_valid};
            out_vld_reg <= vld_reg[STEPS];
        end
    end

    assign out_valid  = out_vld_reg;
    assign half_angle = ang_reg;

endmodule

### rtl/core/great_circle_distance_top.sv
// Haversine great-circle distance pipeline, one point pair per cycle.
// Latency is set by the angle conversion, the two CORDIC pipelines, the haversine stages,
// the square-root pipeline and the final scaling.
// Throughput: one item per cycle; a stalled output freezes the whole pipeline.
// Reset clears all valid bits and loads sphere_radius with 6371000.
module great_circle_distance_top
    import gcd_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEFAULT
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    gcd_in_if.sink             points,
    gcd_out_if.source          result
);
    localparam logic REG_SPHERE_RADIUS = 1'b0;
    localparam int   UPROD_W = ROOT_W + 30;
    localparam int   DPROD_W = RADIUS_W + 32 + 1;

    logic                en;
    logic [RADIUS_W-1:0] radius_reg;
    logic                reg_idx;

    logic   conv_vld, trig_vld, root_vld, ang_vld;
    angle_t angle [LANES];
    trig_t  trig  [LANES];
    root_t  root_a, root_b, half_angle;

    trig_t  sdec2_reg, c12_reg, sra2_reg, sdec2_p2_reg, prod_reg;
    root_t  hav_reg, hav_next;
    logic   vld_p1_reg, vld_p2_reg, vld_p3_reg;
    logic [31:0]       u_reg, u_next;
    logic              u_vld_reg;
    logic [DIST_W-1:0] dist_reg, dist_next;
    logic              out_vld_reg;

    // Q30 product, rounded half up
    function automatic trig_t mul_q30(trig_t a, trig_t b);
        logic signed [2*TRIG_W-1:0] p;
        p = (2*TRIG_W)'(a) * (2*TRIG_W)'(b);
        p = p + ((2*TRIG_W)'(1) <<< 29);
        return TRIG_W'(p >>> 30);
    endfunction

    // Advance the pipeline unless the result waits untaken
    assign en           = !out_vld_reg || result.ready;
    assign points.ready = en;

    // Configuration register: write on the access phase, word index in the top bit
    assign reg_idx = paddr[PADDR_W-1];
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            radius_reg <= RADIUS_RESET;
        else if (psel && penable && pwrite)
        begin
            unique case (reg_idx)
                REG_SPHERE_RADIUS: radius_reg <= pwdata[RADIUS_W-1:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_SPHERE_RADIUS: prdata = PDATA_W'(radius_reg);
            default:           prdata = '0;
        endcase
    end

    gcd_angle_conv u_conv (
        .clk                (clk),
        .rst_n              (rst_n),
        .en                 (en),
        .in_valid           (points.valid),
        .first_ascension    (points.first_ascension),
        .first_declination  (points.first_declination),
        .second_ascension   (points.second_ascension),
        .second_declination (points.second_declination),
        .out_valid          (conv_vld),
        .angle              (angle)
    );

    gcd_sincos #(.STEPS(CORDIC_STEPS)) u_sincos (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (conv_vld),
        .angle     (angle),
        .out_valid (trig_vld),
        .value     (trig)
    );

    // Haversine term over three stages, clamped to [0, 1]
    always_comb
    begin
        logic signed [TRIG_W:0] sum;
        sum = (TRIG_W+1)'(sdec2_p2_reg) + (TRIG_W+1)'(prod_reg);
        if (sum[TRIG_W])
            hav_next = '0;
        else if (sum > signed'((TRIG_W+1)'(Q30_ONE)))
            hav_next = Q30_ONE;
        else
            hav_next = ROOT_W'(sum);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sdec2_reg    <= mul_q30(trig[LANE_DDEC], trig[LANE_DDEC]);
            c12_reg      <= mul_q30(trig[LANE_DEC1], trig[LANE_DEC2]);
            sra2_reg     <= mul_q30(trig[LANE_DRA], trig[LANE_DRA]);
            sdec2_p2_reg <= sdec2_reg;
            prod_reg     <= mul_q30(c12_reg, sra2_reg);
            hav_reg      <= hav_next;
        end
    end

    gcd_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (vld_p3_reg),
        .hav       (hav_reg),
        .out_valid (root_vld),
        .root_a    (root_a),
        .root_b    (root_b)
    );

    gcd_atan #(.STEPS(CORDIC_STEPS)) u_atan (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_valid   (root_vld),
        .y_in       (root_a),
        .x_in       (root_b),
        .out_valid  (ang_vld),
        .half_angle (half_angle)
    );

    // Central angle in radians (Q30), then scale by the radius
    always_comb
    begin
        logic [UPROD_W-1:0] up;
        logic [DPROD_W-1:0] dp;
        up        = UPROD_W'(half_angle) * UPROD_W'(PI_Q28) + (UPROD_W'(1) << 27);
        u_next    = 32'(up >> 28);
        dp        = DPROD_W'(radius_reg) * DPROD_W'(u_reg) + (DPROD_W'(1) << 29);
        dist_next = DIST_W'(dp >> 30);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            u_reg    <= u_next;
            dist_reg <= dist_next;
        end
    end

    // Advance valid bits with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_p1_reg  <= 1'b0;
            vld_p2_reg  <= 1'b0;
            vld_p3_reg  <= 1'b0;
            u_vld_reg   <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_p1_reg  <= trig_vld;
            vld_p2_reg  <= vld_p1_reg;
            vld_p3_reg  <= vld_p2_reg;
            u_vld_reg   <= ang_vld;
            out_vld_reg <= u_vld_reg;
        end
    end

    assign result.valid    = out_vld_reg;
    assign result.distance = dist_reg;

`ifndef SYNTHESIS
    a_last_stage_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (u_vld_reg && points.ready) |=> result.valid)
        else $error("scaled item did not reach the output register");

    a_roots_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        root_vld |-> (root_a <= Q30_ONE && root_b <= Q30_ONE))
        else $error("square root above one");

    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.ready) |-> !points.ready)
        else $error("input taken while result is stalled");
`endif

endmodule
